// File: sv/jebw_pkg.sv
// Package for the JPEG entropy bit writer: operation codes and the
// command record passed from the packer front end to the byte back end.
// No dependencies.
package jebw_pkg;

  typedef enum logic [1:0] {
    OP_PUT      = 2'd0,
    OP_ALIGN    = 2'd1,
    OP_RAW_BYTE = 2'd2,
    OP_RAW_WORD = 2'd3
  } op_t;

  localparam logic [7:0] STUFF_MATCH = 8'hFF;
  localparam logic [7:0] STUFF_BYTE  = 8'h00;

  // word: bytes to send, high byte first; a single byte sits in the high half
  typedef struct packed {
    logic [15:0] word;
    logic        two;
    logic        stuff;
  } cmd_t;

endpackage

// File: sv/jebw_ifs.sv
// Channel interfaces of the JPEG entropy bit writer: input items and
// output bytes, each with valid/ready. No dependencies.
interface jebw_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] code_value;
  logic [4:0]  code_length;
  modport source(output valid, operation, code_value, code_length, input ready);
  modport sink(input valid, operation, code_value, code_length, output ready);
endinterface

interface jebw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  modport source(output valid, out_byte, last_byte, input ready);
  modport sink(input valid, out_byte, last_byte, output ready);
endinterface

// File: sv/jebw_front.sv
// Front end of the JPEG entropy bit writer: accepts items, packs code bits
// into the pending accumulator and queues byte commands.
// Depends on jebw_pkg and jebw_ifs.
module jebw_front (
  input  logic           clk,
  input  logic           rst,
  jebw_item_if.sink      item,
  input  logic           full,
  output logic           push,
  output jebw_pkg::cmd_t cmd,
  output logic [3:0]     pend_count
);

  logic [15:0] bits;
  logic [15:0] bits_next;
  logic [3:0]  count;
  logic [3:0]  count_next;
  logic        accept;
  logic        want;
  logic [4:0]  len;
  logic [16:0] mask;
  logic [15:0] code_m;
  logic [4:0]  total;
  logic [5:0]  shamt;
  logic [31:0] acc;
  logic [15:0] padded;

  assign accept     = item.valid && !full;
  assign item.ready = !full;
  assign push       = accept && want;
  assign pend_count = count;

  always_comb begin
    len    = item.code_length[4] ? 5'd16 : item.code_length;
    mask   = (17'd1 << len) - 17'd1;
    code_m = item.code_value & mask[15:0];
    total  = {1'b0, count} + len;
    shamt  = 6'd32 - {1'b0, total};
    acc    = {bits, 16'h0000} | ({16'h0000, code_m} << shamt);
    padded = bits | (16'hFFFF >> count);
  end

  always_comb begin
    want       = 1'b0;
    cmd        = '0;
    bits_next  = bits;
    count_next = count;
    case (jebw_pkg::op_t'(item.operation))
      jebw_pkg::OP_PUT: begin
        count_next = total[3:0];
        if (total[4]) begin
          want      = 1'b1;
          cmd.word  = acc[31:16];
          cmd.two   = 1'b1;
          cmd.stuff = 1'b1;
          bits_next = acc[15:0];
        end else begin
          bits_next = acc[31:16];
        end
      end
      jebw_pkg::OP_ALIGN: begin
        want       = (count != 4'd0);
        cmd.word   = padded;
        cmd.two    = (count > 4'd8);
        cmd.stuff  = 1'b1;
        bits_next  = 16'h0000;
        count_next = 4'd0;
      end
      jebw_pkg::OP_RAW_BYTE: begin
        want     = 1'b1;
        cmd.word = {item.code_value[7:0], 8'h00};
      end
      jebw_pkg::OP_RAW_WORD: begin
        want     = 1'b1;
        cmd.word = item.code_value;
        cmd.two  = 1'b1;
      end
      default: begin
        want = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits  <= 16'h0000;
      count <= 4'd0;
    end else if (accept) begin
      bits  <= bits_next;
      count <= count_next;
    end
  end

endmodule

// File: sv/jebw_cmd_fifo.sv
// Command queue between the front and back ends of the JPEG entropy bit
// writer. Depends on jebw_pkg.
module jebw_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  jebw_pkg::cmd_t wr_cmd,
  input  logic           pop,
  output jebw_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  jebw_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign empty   = (count == '0);
  assign full    = (count == FULL_COUNT);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

// File: sv/jebw_back.sv
// Back end of the JPEG entropy bit writer: sends queued command bytes one
// per cycle while the output is ready, inserting a zero after 0xFF when
// stuffing is on. Depends on jebw_pkg and jebw_ifs.
module jebw_back (
  input  logic           clk,
  input  logic           rst,
  input  jebw_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  jebw_byte_if.source    result
);

  logic       idx;
  logic       in_stuff;
  logic       load;
  logic [7:0] cur;
  logic       need_stuff;
  logic       last;

  always_comb begin
    load       = !empty && (!result.valid || result.ready);
    cur        = in_stuff ? jebw_pkg::STUFF_BYTE
               : (idx ? head.word[7:0] : head.word[15:8]);
    need_stuff = !in_stuff && head.stuff && (cur == jebw_pkg::STUFF_MATCH);
    last       = (idx == head.two) && !need_stuff;
    pop        = load && last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_byte  <= cur;
      result.last_byte <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      idx          <= 1'b0;
      in_stuff     <= 1'b0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (load) begin
        if (need_stuff) begin
          in_stuff <= 1'b1;
        end else begin
          in_stuff <= 1'b0;
          idx      <= last ? 1'b0 : 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/jpeg_entropy_bit_writer_unit.sv
// Top level of the JPEG entropy bit writer: front end, command queue and
// byte back end. Depends on jebw_pkg, jebw_ifs, jebw_front, jebw_cmd_fifo,
// jebw_back.
//
//  channel  modport  payload                                 role
//  item     sink     operation, code_value, code_length      codes and raw bytes
//  result   source   out_byte, last_byte                     output byte stream
//
// An item is taken every cycle while the command queue has room; it yields
// zero to four bytes. The back end sends one byte per cycle from a register
// while the byte port is ready, so the byte port sets the sustained rate. An
// item's first byte goes through the command queue, then the output register.
// Synchronous reset clears the pending bits, the queue and the output valid. A
// stalled output fills the queue (QUEUE_DEPTH commands) before the input stalls.
module jpeg_entropy_bit_writer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  jebw_item_if.sink    item,
  jebw_byte_if.source  result
);

  jebw_pkg::cmd_t wr_cmd;
  jebw_pkg::cmd_t head;
  logic           push;
  logic           pop;
  logic           empty;
  logic           full;
  logic [3:0]     pend_count;

  jebw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .full       (full),
    .push       (push),
    .cmd        (wr_cmd),
    .pend_count (pend_count)
  );

  jebw_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  jebw_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  a_align_clears: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.operation == jebw_pkg::OP_ALIGN)
      |=> (pend_count == 4'd0))
    else $error("align left pending bits");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty command queue");

  a_mid_command: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.last_byte) |-> !empty)
    else $error("command retired before its last byte");

endmodule
